/* rtl/core/saturating_integrator_moving_average_core_assert.svh */
// Assertion macros shared by the checker of the saturating integrator core.
// Depends on nothing; include by bare file name.
`ifndef SATURATING_INTEGRATOR_MOVING_AVERAGE_CORE_ASSERT_SVH
`define SATURATING_INTEGRATOR_MOVING_AVERAGE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SIMA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sima assertion failed");

// Next-cycle implication, checked outside reset.
`define SIMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sima assertion failed");

`endif

/* rtl/core/sima_pkg.sv */
// Shared widths, constants and the saturating position add.
// No dependencies.
`default_nettype none

package sima_pkg;

    localparam int unsigned POS_W   = 16;
    localparam int unsigned LEVEL_W = 8;

    localparam logic [POS_W-1:0]   POS_RESET = 16'h7fff;
    localparam logic [POS_W-1:0]   POS_MAX   = 16'hffff;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'hff;

    typedef logic [POS_W-1:0] t_pos;

    // Clamp base + delta to 0..65535.
    function automatic t_pos sat_add(input t_pos base, input logic signed [POS_W-1:0] delta);
        logic signed [POS_W+1:0] s;
        s = $signed({2'b00, base}) + (POS_W+2)'(delta);
        if (s < 0) begin
            sat_add = '0;
        end else if (s > $signed({2'b00, POS_MAX})) begin
            sat_add = POS_MAX;
        end else begin
            sat_add = s[POS_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/core/saturating_integrator_moving_average_core.sv */
// Saturating integrator followed by a TAPS-deep boxcar average.
// Uses sima_pkg; the window is held in an internal synchronous RAM.
//
// Usage
//   Input channel : i_in_valid / o_in_ready, word = i_accel_change (signed 16 bit).
//   Output channel: o_out_valid / i_out_ready, word = o_filtered_level (8 bit)
//                   and o_newest_position (16 bit). One output word per input word.
//   Each input word is added to the last stored position, clamped to 0..65535,
//   and written into a ring buffer over the oldest entry. A running sum swaps
//   the oldest entry for the new one; the level is sum >> (floor(log2 TAPS)+8),
//   clamped to 255.
//   Each word is registered in stage 1 (r_v1), then in the output stage (r_vo).
//   Throughput: one word per cycle while i_out_ready stays high; the position
//   feedback and the running-sum update each close through one register, and the
//   RAM is read one entry ahead of the write pointer to hide its registered read.
//   Reset (synchronous, active low): the window reads as 0x7fff everywhere
//   without a clearing pass; entries not yet written in the first lap are
//   substituted by 0x7fff. The block accepts input the cycle after reset.
//   Stall: when the receiver holds i_out_ready low, a word is still taken into
//   the first stage if it is empty, then o_in_ready drops until the output moves.
`default_nettype none

module saturating_integrator_moving_average_core #(
    parameter int unsigned TAPS = 128
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic signed [sima_pkg::POS_W-1:0]    i_accel_change,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic [sima_pkg::LEVEL_W-1:0]              o_filtered_level,
    output logic [sima_pkg::POS_W-1:0]                o_newest_position
);

    localparam int unsigned PW    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int unsigned SUM_W = $clog2(TAPS) + sima_pkg::POS_W;
    localparam int unsigned SH    = $clog2(TAPS + 1) - 1 + sima_pkg::LEVEL_W;
    localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(64'(sima_pkg::POS_RESET) * 64'(TAPS));
    localparam logic [PW-1:0]    WP_LAST   = PW'(TAPS - 1);

    // window RAM, registered read
    sima_pkg::t_pos r_mem [TAPS];
    sima_pkg::t_pos r_rd;

    logic [PW-1:0]  r_wp, n_wp;
    logic           r_wrapped;        // first lap done: RAM data is real
    sima_pkg::t_pos r_newest;

    // stage 1
    logic           r_v1;
    sima_pkg::t_pos r_pos1, r_old1;

    // stage 2 / output
    logic                        r_vo;
    logic [SUM_W-1:0]            r_sum, n_sum;
    logic [sima_pkg::LEVEL_W-1:0] r_level, n_level;
    sima_pkg::t_pos              r_pos_out;

    logic           en, accept;
    sima_pkg::t_pos pos_new, oldest;
    logic [SUM_W-1:0] shifted;

    assign en         = !r_vo || i_out_ready;
    assign o_in_ready = en || !r_v1;
    assign accept     = i_in_valid && o_in_ready;

    assign pos_new = sima_pkg::sat_add(r_newest, i_accel_change);
    assign oldest  = r_wrapped ? r_rd : sima_pkg::POS_RESET;

    always_comb begin
        n_wp = r_wp;
        if (accept) begin
            n_wp = (r_wp == WP_LAST) ? '0 : r_wp + 1'b1;
        end
    end

    // Read one slot ahead: the next oldest entry is ready when it is needed.
    // The write goes to r_wp, never to the address read in the same cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_wp] <= pos_new;
        end
        r_rd <= r_mem[n_wp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
            r_newest  <= sima_pkg::POS_RESET;
            r_v1      <= 1'b0;
        end else begin
            r_wp <= n_wp;
            if (accept) begin
                r_newest <= pos_new;
                if (r_wp == WP_LAST) begin
                    r_wrapped <= 1'b1;
                end
                r_v1 <= 1'b1;
            end else if (en) begin
                r_v1 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos1 <= pos_new;
            r_old1 <= oldest;
        end
    end

    assign n_sum   = r_sum - SUM_W'(r_old1) + SUM_W'(r_pos1);
    assign shifted = n_sum >> SH;
    assign n_level = (|shifted[SUM_W-1:sima_pkg::LEVEL_W]) ? sima_pkg::LEVEL_MAX
                                                          : shifted[sima_pkg::LEVEL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo  <= 1'b0;
            r_sum <= SUM_RESET;
        end else if (en) begin
            r_vo <= r_v1;
            if (r_v1) begin
                r_sum <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_v1) begin
            r_level   <= n_level;
            r_pos_out <= r_pos1;
        end
    end

    assign o_out_valid       = r_vo;
    assign o_filtered_level  = r_level;
    assign o_newest_position = r_pos_out;

endmodule

`default_nettype wire

/* rtl/core/sima_checker.sv */
// Port-level checker for the saturating integrator core, plus its bind.
// Uses sima_pkg and saturating_integrator_moving_average_core_assert.svh.
`default_nettype none

`include "saturating_integrator_moving_average_core_assert.svh"

module sima_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_in_valid,
    input wire logic                                 o_in_ready,
    input wire logic signed [sima_pkg::POS_W-1:0]    i_accel_change,
    input wire logic                                 o_out_valid,
    input wire logic                                 i_out_ready,
    input wire logic [sima_pkg::LEVEL_W-1:0]         o_filtered_level,
    input wire logic [sima_pkg::POS_W-1:0]           o_newest_position
);

    logic out_stall;
    assign out_stall = o_out_valid && !i_out_ready;

    // input backpressure only comes from a stalled output
    `SIMA_ASSERT_NOW(a_ready_low_only_on_stall, i_clk, i_rst_n, !o_in_ready, out_stall)

    // nothing comes out right after reset
    `SIMA_ASSERT_NOW(a_no_out_after_reset, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid)

    // an input accepted while the output moves shows up if the output keeps moving
    `SIMA_ASSERT_NEXT(a_accept_reaches_out, i_clk, i_rst_n,
        i_in_valid && o_in_ready && !out_stall ##1 !out_stall, o_out_valid)

    // stalled output word holds
    `SIMA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall,
        o_out_valid && $stable(o_filtered_level) && $stable(o_newest_position))

    // waiting input word holds
    `SIMA_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && !o_in_ready,
        i_in_valid && $stable(i_accel_change))

endmodule

bind saturating_integrator_moving_average_core sima_checker u_sima_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .i_accel_change    (i_accel_change),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_filtered_level  (o_filtered_level),
    .o_newest_position (o_newest_position)
);

`default_nettype wire

/* verif/tb_saturating_integrator_moving_average_core.sv */
// Testbench for saturating_integrator_moving_average_core: drives signed position
// changes, predicts the clamped position and the boxcar level, checks every output word.
// Depends on sima_pkg and the core RTL; self-contained otherwise.

module tb_saturating_integrator_moving_average_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned POS_W   = sima_pkg::POS_W;
    localparam int unsigned LEVEL_W = sima_pkg::LEVEL_W;
    localparam logic [POS_W-1:0]   POS_RESET = sima_pkg::POS_RESET;
    localparam logic [POS_W-1:0]   POS_MAX   = sima_pkg::POS_MAX;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = sima_pkg::LEVEL_MAX;
    typedef sima_pkg::t_pos t_pos;

    localparam int unsigned TAPS        = 128;
    // Level shift is floor(log2 TAPS) + 8.
    localparam int unsigned LEVEL_SHIFT = $clog2(TAPS + 1) - 1 + 8;
    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_WORDS = 1275;
    localparam int unsigned QUIET_WORDS  = 150;

    // Shape of a run of random changes.
    typedef enum int unsigned {
        DRIFT_ANY,
        DRIFT_JITTER,
        DRIFT_CLIMB,
        DRIFT_FALL,
        DRIFT_HOLD
    } t_drift;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        t_pos               position;
    } t_filter_out;

    // ------------------------------------------------------------------
    // Scoreboard: keeps its own window of positions and the running sum,
    // and queues the output word each accepted input word should produce.
    // ------------------------------------------------------------------
    class boxcar_scoreboard;
        t_pos              window_mem[TAPS];
        logic [31:0]       window_sum;
        int unsigned       oldest_idx;
        t_filter_out       expected_words[$];
        int unsigned       errors;

        function void clear();
            for (int i = 0; i < TAPS; i++) begin
                window_mem[i] = POS_RESET;
            end
            window_sum = 32'(POS_RESET) * TAPS;
            oldest_idx = 0;
            expected_words.delete();
            errors = 0;
        endfunction

        function int unsigned pending();
            return expected_words.size();
        endfunction

        // Integrate one change and slide the window.
        function void note_input(logic signed [POS_W-1:0] change);
            t_pos        newest;
            int          total;
            t_pos        position;
            logic [31:0] level_wide;
            t_filter_out word;
            newest = window_mem[(oldest_idx + TAPS - 1) % TAPS];
            total  = int'(newest) + int'(change);
            if (total < 0) begin
                position = '0;
            end else if (total > int'(POS_MAX)) begin
                position = POS_MAX;
            end else begin
                position = t_pos'(total);
            end
            window_sum = window_sum - 32'(window_mem[oldest_idx]) + 32'(position);
            window_mem[oldest_idx] = position;
            oldest_idx = (oldest_idx + 1) % TAPS;
            level_wide = window_sum >> LEVEL_SHIFT;
            word.level    = (level_wide > 32'(LEVEL_MAX)) ? LEVEL_MAX : level_wide[LEVEL_W-1:0];
            word.position = position;
            expected_words.push_back(word);
        endfunction

        function void check_result(logic [LEVEL_W-1:0] level, t_pos position);
            t_filter_out want;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected output word level=%0d position=%0d",
                         $time, level, position);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (level !== want.level) begin
                $display("%0t: filtered_level mismatch expected=%0d actual=%0d",
                         $time, want.level, level);
                errors++;
            end
            if (position !== want.position) begin
                $display("%0t: newest_position mismatch expected=%0d actual=%0d",
                         $time, want.position, position);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value.
    // ------------------------------------------------------------------
    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_in_valid     = 1'b0;
    logic signed [POS_W-1:0] i_accel_change = '0;
    logic                    i_out_ready    = 1'b0;
    logic                    o_in_ready;
    logic                    o_out_valid;
    logic [LEVEL_W-1:0]      o_filtered_level;
    t_pos                    o_newest_position;

    saturating_integrator_moving_average_core #(
        .TAPS (TAPS)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_accel_change    (i_accel_change),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_filtered_level  (o_filtered_level),
        .o_newest_position (o_newest_position)
    );

    boxcar_scoreboard sb = new;

    bit          idle_enable  = 1'b1;   // random bursts of idling on both sides
    bit          hold_request = 1'b0;   // asks the sink for one long hold-off
    int unsigned cycle_count  = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: any hang ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_saturating_integrator_moving_average_core failed");
            $finish;
        end
    end

    // Handshake monitors. Values read right at the edge are the pre-edge ones,
    // since every driver here and in the RTL updates through NBAs.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            sb.note_input(i_accel_change);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_filtered_level, o_newest_position);
        end
    end

    // Sink side: ready stays up for random stretches, drops in idle bursts while
    // idle_enable is set, and on request holds off long enough that the core backs up
    // into its input.
    initial begin
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (idle_enable && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------

    // Offer one word and hold it until the core takes it.
    task automatic send_word(input logic signed [POS_W-1:0] change);
        i_in_valid     <= 1'b1;
        i_accel_change <= change;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
    endtask

    // Optionally idle for a burst, then offer the word.
    task automatic offer_word(input logic signed [POS_W-1:0] change);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        send_word(change);
    endtask

    // Source stays quiet until every predicted word has come back.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [POS_W-1:0] next_change(t_drift drift);
        logic signed [POS_W-1:0] change;
        case (drift)
            DRIFT_ANY:    change = POS_W'($urandom_range(0, 65535));
            DRIFT_JITTER: change = POS_W'(int'($urandom_range(0, 511)) - 256);
            DRIFT_CLIMB:  change = POS_W'($urandom_range(0, 4095));
            DRIFT_FALL:   change = POS_W'(-int'($urandom_range(0, 4096)));
            default:      change = ($urandom_range(0, 7) == 0)
                                   ? POS_W'(int'($urandom_range(0, 2)) - 1) : '0;
        endcase
        return change;
    endfunction

    // Random words in runs of one drift shape, so the position walks to both
    // rails and the window fills with them, with full-range noise mixed in.
    task automatic random_words(input int unsigned count);
        t_drift      drift;
        int unsigned run_left;
        run_left = 0;
        drift    = DRIFT_ANY;
        for (int unsigned n = 0; n < count; n++) begin
            if (run_left == 0) begin
                drift    = t_drift'($urandom_range(0, 4));
                run_left = $urandom_range(8, 160);
            end
            run_left--;
            offer_word(next_change(drift));
        end
    endtask

    // Directed words: zero, unit steps, both extremes, a climb into the top rail
    // and a fall into the bottom rail, pushes past each rail, and alternating
    // bit patterns.
    logic signed [POS_W-1:0] directed_words[] = '{
        16'sh0000, 16'sh0001, 16'shffff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
        16'sh0001, 16'sh0000, 16'sh8000, 16'sh8000, 16'sh8000, 16'shffff,
        16'sh8000, 16'sh0000, 16'sh0001, 16'sh8000, 16'sh7fff, 16'sh8001,
        16'sh5555, 16'shaaaa, 16'sh00ff, 16'shff00, 16'sh7fff, 16'sh7fff
    };

    initial begin
        sb.clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_words[k]) begin
            offer_word(directed_words[k]);
        end
        wait_for_drain();

        // Long hold-off on the sink while the source keeps pushing.
        hold_request = 1'b1;
        for (int k = 0; k < 24; k++) begin
            send_word(next_change(DRIFT_ANY));
        end

        random_words((RANDOM_WORDS - QUIET_WORDS) / 2);
        wait_for_drain();
        random_words((RANDOM_WORDS - QUIET_WORDS) / 2);

        // Closing stretch at full rate on both sides.
        idle_enable = 1'b0;
        random_words(QUIET_WORDS);

        wait_for_drain();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_saturating_integrator_moving_average_core passed");
        end else begin
            $display("tb_saturating_integrator_moving_average_core failed");
        end
        $finish;
    end

endmodule
